@@ hw/rtl/line_rect_edge_anchor_assert.svh @@
// assertion macros shared by the line_rect_edge_anchor rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef LINE_RECT_EDGE_ANCHOR_ASSERT_SVH
`define LINE_RECT_EDGE_ANCHOR_ASSERT_SVH
`ifndef SYNTHESIS
`define LREA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_rect_edge_anchor: same-cycle check failed");
`define LREA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_rect_edge_anchor: next-cycle check failed");
`else
`define LREA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define LREA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/lrea_pkg.sv @@
// shared widths, codes and types of the line_rect_edge_anchor block
// no dependencies
package lrea_pkg;

    localparam int COORD_BITS    = 16;
    localparam int DIFF_BITS     = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
    localparam int PROD_BITS     = 2 * DIFF_BITS;
    localparam int QCAP_LOG      = 40;
    localparam int QUOT_BITS     = (PROD_BITS > QCAP_LOG + 1) ? PROD_BITS : QCAP_LOG + 1;
    localparam int SUM_BITS      = QUOT_BITS + 2;
    localparam int DELTA_BITS    = DIFF_BITS + 1;
    localparam int DIST_BITS     = 2 * DELTA_BITS + 1;
    localparam int DIM_BITS      = 15;
    localparam int MARGIN_BITS   = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 15;

    localparam logic [DIM_BITS-1:0]    RESET_WIDTH  = DIM_BITS'(100);
    localparam logic [DIM_BITS-1:0]    RESET_HEIGHT = DIM_BITS'(100);
    localparam logic [MARGIN_BITS-1:0] RESET_MARGIN = MARGIN_BITS'(1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RECT_WIDTH,
        CFG_RECT_HEIGHT,
        CFG_EDGE_MARGIN
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SIDE_TOP_LEFT,
        SIDE_TOP,
        SIDE_TOP_RIGHT,
        SIDE_RIGHT,
        SIDE_BOTTOM_RIGHT,
        SIDE_BOTTOM,
        SIDE_BOTTOM_LEFT,
        SIDE_LEFT
    } t_side;

    // hit data handed to the edge picker
    typedef struct packed {
        logic                         vt;
        logic                         vb;
        logic                         vl;
        logic                         vr;
        logic [DIST_BITS-1:0]         dt;
        logic [DIST_BITS-1:0]         db;
        logic [DIST_BITS-1:0]         dl;
        logic [DIST_BITS-1:0]         dr;
        logic signed [DIFF_BITS-1:0]  xt;
        logic signed [DIFF_BITS-1:0]  xb;
        logic signed [DIFF_BITS-1:0]  yl;
        logic signed [DIFF_BITS-1:0]  yr;
        logic signed [COORD_BITS-1:0] y0;
    } t_hits;

    typedef struct packed {
        logic                         found;
        t_side                        side;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
    } t_result;

endpackage

@@ hw/rtl/line_rect_edge_anchor.sv @@
// top level: config registers, line setup, dividers, hit test, distances, output
// depends on lrea_pkg, lrea_div_pipe, lrea_pick, line_rect_edge_anchor_assert.svh
//
//  channel  | valid   | stall   | payload
//  ---------+---------+---------+-----------------------------------------
//  input    | i_valid | o_stall | i_tip_x i_tip_y i_loc_x i_loc_y
//  result   | o_valid | i_stall | o_found o_side o_anchor_x o_anchor_y
//  config   | i_cfg_we| -       | i_cfg_idx i_cfg_data
//
// one item per cycle while the result is not stalled; the divider pipeline
// resolves one quotient bit per stage.
// reset clears all valid bits and loads the register defaults; no clearing pass.
// a held result under stall freezes the whole pipeline; nothing is lost or repeated.
module line_rect_edge_anchor (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [lrea_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [lrea_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [lrea_pkg::COORD_BITS-1:0] i_tip_x,
    input  logic signed [lrea_pkg::COORD_BITS-1:0] i_tip_y,
    input  logic signed [lrea_pkg::COORD_BITS-1:0] i_loc_x,
    input  logic signed [lrea_pkg::COORD_BITS-1:0] i_loc_y,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_found,
    output logic [2:0]                             o_side,
    output logic signed [lrea_pkg::COORD_BITS-1:0] o_anchor_x,
    output logic signed [lrea_pkg::COORD_BITS-1:0] o_anchor_y
);
    import lrea_pkg::*;

    `include "line_rect_edge_anchor_assert.svh"

    localparam int NS = PROD_BITS;

    typedef struct packed {
        logic                         valid;
        logic signed [COORD_BITS-1:0] x0;
        logic signed [COORD_BITS-1:0] y0;
        logic                         neg_t;
        logic                         neg_b;
        logic                         neg_l;
        logic                         neg_r;
        logic                         dx_nz;
        logic                         dy_nz;
    } t_band;

    logic en;

    // configuration registers
    logic [DIM_BITS-1:0]    r_w;
    logic [DIM_BITS-1:0]    r_h;
    logic [MARGIN_BITS-1:0] r_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= RESET_WIDTH;
            r_h <= RESET_HEIGHT;
            r_m <= RESET_MARGIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RECT_WIDTH:  r_w <= i_cfg_data[DIM_BITS-1:0];
                CFG_RECT_HEIGHT: r_h <= i_cfg_data[DIM_BITS-1:0];
                CFG_EDGE_MARGIN: r_m <= i_cfg_data[MARGIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic signed [DIFF_BITS-1:0] w_e, h_e;
    assign w_e = $signed({{(DIFF_BITS-DIM_BITS){1'b0}}, r_w});
    assign h_e = $signed({{(DIFF_BITS-DIM_BITS){1'b0}}, r_h});

    // whole pipeline advances unless a held result is stalled
    logic r_o_valid;
    assign en      = !(r_o_valid && i_stall);
    assign o_stall = !en;

    function automatic logic [DIFF_BITS-1:0] mag(logic signed [DIFF_BITS-1:0] v);
        return v[DIFF_BITS-1] ? DIFF_BITS'(-v) : DIFF_BITS'(v);
    endfunction

    // stage a: deltas and edge offsets
    logic                         r_a_valid;
    logic signed [COORD_BITS-1:0] r_a_x0, r_a_y0;
    logic signed [DIFF_BITS-1:0]  r_a_dx, r_a_dy, r_a_at, r_a_ab, r_a_al, r_a_ar;
    logic signed [DIFF_BITS-1:0]  x0e, y0e, x1e, y1e;

    assign x0e = DIFF_BITS'(i_tip_x);
    assign y0e = DIFF_BITS'(i_tip_y);
    assign x1e = DIFF_BITS'(i_loc_x);
    assign y1e = DIFF_BITS'(i_loc_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_x0 <= i_tip_x;
            r_a_y0 <= i_tip_y;
            r_a_dx <= x1e - x0e;
            r_a_dy <= y1e - y0e;
            r_a_at <= -y0e;
            r_a_ab <= h_e - y0e;
            r_a_al <= -x0e;
            r_a_ar <= w_e - x0e;
        end
    end

    // stage b: magnitude products and quotient signs
    t_band                r_b_band;
    logic [PROD_BITS-1:0] r_b_num_t, r_b_num_b, r_b_num_l, r_b_num_r;
    logic [DIFF_BITS-1:0] r_b_den_x, r_b_den_y;
    logic                 sx, sy;

    assign sx = r_a_dx[DIFF_BITS-1];
    assign sy = r_a_dy[DIFF_BITS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_band.valid <= 1'b0;
        end else if (en) begin
            r_b_band.valid <= r_a_valid;
            r_b_band.x0    <= r_a_x0;
            r_b_band.y0    <= r_a_y0;
            r_b_band.neg_t <= r_a_at[DIFF_BITS-1] ^ sx ^ sy;
            r_b_band.neg_b <= r_a_ab[DIFF_BITS-1] ^ sx ^ sy;
            r_b_band.neg_l <= r_a_al[DIFF_BITS-1] ^ sy ^ sx;
            r_b_band.neg_r <= r_a_ar[DIFF_BITS-1] ^ sy ^ sx;
            r_b_band.dx_nz <= r_a_dx != '0;
            r_b_band.dy_nz <= r_a_dy != '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_num_t <= PROD_BITS'(mag(r_a_at)) * PROD_BITS'(mag(r_a_dx));
            r_b_num_b <= PROD_BITS'(mag(r_a_ab)) * PROD_BITS'(mag(r_a_dx));
            r_b_num_l <= PROD_BITS'(mag(r_a_al)) * PROD_BITS'(mag(r_a_dy));
            r_b_num_r <= PROD_BITS'(mag(r_a_ar)) * PROD_BITS'(mag(r_a_dy));
            r_b_den_x <= mag(r_a_dx);
            r_b_den_y <= mag(r_a_dy);
        end
    end

    // divider pipelines with side band alongside
    logic [PROD_BITS-1:0] q_t, q_b, q_l, q_r;
    logic                 rz_t, rz_b, rz_l, rz_r;

    lrea_div_pipe u_div_t (.i_clk(i_clk), .i_en(en), .i_num(r_b_num_t), .i_den(r_b_den_y),
                           .o_quot(q_t), .o_rem_nz(rz_t));
    lrea_div_pipe u_div_b (.i_clk(i_clk), .i_en(en), .i_num(r_b_num_b), .i_den(r_b_den_y),
                           .o_quot(q_b), .o_rem_nz(rz_b));
    lrea_div_pipe u_div_l (.i_clk(i_clk), .i_en(en), .i_num(r_b_num_l), .i_den(r_b_den_x),
                           .o_quot(q_l), .o_rem_nz(rz_l));
    lrea_div_pipe u_div_r (.i_clk(i_clk), .i_en(en), .i_num(r_b_num_r), .i_den(r_b_den_x),
                           .o_quot(q_r), .o_rem_nz(rz_r));

    t_band r_band [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_band[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_band[0] <= r_b_band;
            for (int k = 1; k < NS; k++) begin
                r_band[k] <= r_band[k-1];
            end
        end
    end

    t_band band_q;
    assign band_q = r_band[NS-1];

    // signed hit coordinate, truncated toward zero
    function automatic logic signed [SUM_BITS-1:0] hit_coord(
        logic signed [COORD_BITS-1:0] p0, logic [PROD_BITS-1:0] q, logic rnz, logic neg);
        logic [QUOT_BITS-1:0]        tq;
        logic [QUOT_BITS-1:0]        cap;
        logic signed [SUM_BITS-1:0]  mag_s;
        logic signed [SUM_BITS-1:0]  s;
        tq    = QUOT_BITS'(q);
        cap   = QUOT_BITS'(1) << QCAP_LOG;
        if (tq > cap) begin
            tq = cap;
        end
        mag_s = $signed({2'b00, tq});
        s     = SUM_BITS'(p0) + (neg ? -mag_s : mag_s);
        if (rnz) begin
            if (s > 0 && neg) begin
                s = s - 1;
            end else if (s < 0 && !neg) begin
                s = s + 1;
            end
        end
        return s;
    endfunction

    // stage c: hit coordinates and edge tests
    logic signed [SUM_BITS-1:0] s_t, s_b, s_l, s_r, w_s, h_s;
    assign s_t = hit_coord(band_q.x0, q_t, rz_t, band_q.neg_t);
    assign s_b = hit_coord(band_q.x0, q_b, rz_b, band_q.neg_b);
    assign s_l = hit_coord(band_q.y0, q_l, rz_l, band_q.neg_l);
    assign s_r = hit_coord(band_q.y0, q_r, rz_r, band_q.neg_r);
    assign w_s = $signed({{(SUM_BITS-DIM_BITS){1'b0}}, r_w});
    assign h_s = $signed({{(SUM_BITS-DIM_BITS){1'b0}}, r_h});

    logic                         r_c_valid;
    logic                         r_c_vt, r_c_vb, r_c_vl, r_c_vr;
    logic signed [DIFF_BITS-1:0]  r_c_xt, r_c_xb, r_c_yl, r_c_yr;
    logic signed [COORD_BITS-1:0] r_c_x0, r_c_y0;
    logic                         hor_ok, ver_ok;

    assign hor_ok = band_q.dy_nz && (r_w != '0);
    assign ver_ok = band_q.dx_nz && (r_h != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= band_q.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_vt <= hor_ok && s_t >= 0 && s_t <= w_s;
            r_c_vb <= hor_ok && s_b >= 0 && s_b <= w_s;
            r_c_vl <= ver_ok && s_l >= 0 && s_l <= h_s;
            r_c_vr <= ver_ok && s_r >= 0 && s_r <= h_s;
            r_c_xt <= s_t[DIFF_BITS-1:0];
            r_c_xb <= s_b[DIFF_BITS-1:0];
            r_c_yl <= s_l[DIFF_BITS-1:0];
            r_c_yr <= s_r[DIFF_BITS-1:0];
            r_c_x0 <= band_q.x0;
            r_c_y0 <= band_q.y0;
        end
    end

    // stage d: squared distances from the tip
    function automatic logic [DIST_BITS-1:0] sq(logic signed [DELTA_BITS-1:0] v);
        logic signed [2*DELTA_BITS-1:0] p;
        p = v * v;
        return DIST_BITS'($unsigned(p));
    endfunction

    logic signed [DELTA_BITS-1:0] x0d, y0d, wd, hd;
    assign x0d = DELTA_BITS'(r_c_x0);
    assign y0d = DELTA_BITS'(r_c_y0);
    assign wd  = $signed({{(DELTA_BITS-DIM_BITS){1'b0}}, r_w});
    assign hd  = $signed({{(DELTA_BITS-DIM_BITS){1'b0}}, r_h});

    logic  r_d_valid;
    t_hits r_d_hits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_hits.vt <= r_c_vt;
            r_d_hits.vb <= r_c_vb;
            r_d_hits.vl <= r_c_vl;
            r_d_hits.vr <= r_c_vr;
            r_d_hits.dt <= sq(x0d - DELTA_BITS'(r_c_xt)) + sq(y0d);
            r_d_hits.db <= sq(x0d - DELTA_BITS'(r_c_xb)) + sq(y0d - hd);
            r_d_hits.dl <= sq(x0d) + sq(y0d - DELTA_BITS'(r_c_yl));
            r_d_hits.dr <= sq(x0d - wd) + sq(y0d - DELTA_BITS'(r_c_yr));
            r_d_hits.xt <= r_c_xt;
            r_d_hits.xb <= r_c_xb;
            r_d_hits.yl <= r_c_yl;
            r_d_hits.yr <= r_c_yr;
            r_d_hits.y0 <= r_c_y0;
        end
    end

    // edge choice and output register
    t_result pick_res;
    t_result r_o_res;

    lrea_pick u_pick (
        .i_hits(r_d_hits),
        .i_w   (r_w),
        .i_h   (r_h),
        .i_m   (r_m),
        .o_res (pick_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_res <= pick_res;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_found    = r_o_res.found;
    assign o_side     = r_o_res.side;
    assign o_anchor_x = r_o_res.ax;
    assign o_anchor_y = r_o_res.ay;

    // checks
    `LREA_ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n, r_o_valid && !r_o_res.found, (r_o_res.side == SIDE_TOP_LEFT) && (r_o_res.ax == '0) && (r_o_res.ay == '0))
    `LREA_ASSERT_IMPLY(a_top_y, i_clk, i_rst_n, r_o_valid && r_o_res.found && (r_o_res.side == SIDE_TOP), r_o_res.ay == '0)
    `LREA_ASSERT_IMPLY(a_left_x, i_clk, i_rst_n, r_o_valid && r_o_res.found && ((r_o_res.side == SIDE_LEFT) || (r_o_res.side == SIDE_TOP_LEFT) || (r_o_res.side == SIDE_BOTTOM_LEFT)), r_o_res.ax == '0)
    `LREA_ASSERT_NEXT(a_freeze, i_clk, i_rst_n, r_c_valid && !en, r_c_valid)

endmodule

@@ hw/rtl/lrea_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage
// depends on lrea_pkg
module lrea_div_pipe (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [lrea_pkg::PROD_BITS-1:0] i_num,
    input  logic [lrea_pkg::DIFF_BITS-1:0] i_den,
    output logic [lrea_pkg::PROD_BITS-1:0] o_quot,
    output logic                           o_rem_nz
);
    import lrea_pkg::*;

    localparam int NS = PROD_BITS;

    logic [PROD_BITS-1:0] r_num  [NS];
    logic [PROD_BITS-1:0] r_quot [NS];
    logic [DIFF_BITS-1:0] r_rem  [NS];
    logic [DIFF_BITS-1:0] r_den  [NS];

    // one stage per quotient bit, msb first
    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [PROD_BITS-1:0] s_num;
        logic [PROD_BITS-1:0] s_quot;
        logic [DIFF_BITS-1:0] s_rem;
        logic [DIFF_BITS-1:0] s_den;
        logic [DIFF_BITS:0]   trial;
        logic                 ge;
        logic [DIFF_BITS-1:0] n_rem;
        logic [DIFF_BITS:0]   diff;

        if (k == 0) begin : g_first
            assign s_num  = i_num;
            assign s_quot = '0;
            assign s_rem  = '0;
            assign s_den  = i_den;
        end else begin : g_next
            assign s_num  = r_num[k-1];
            assign s_quot = r_quot[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_den  = r_den[k-1];
        end

        assign trial = {s_rem, s_num[PROD_BITS-1]};
        assign ge    = trial >= {1'b0, s_den};
        assign diff  = trial - {1'b0, s_den};
        assign n_rem = ge ? diff[DIFF_BITS-1:0] : trial[DIFF_BITS-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= {s_num[PROD_BITS-2:0], 1'b0};
                r_quot[k] <= {s_quot[PROD_BITS-2:0], ge};
                r_rem[k]  <= n_rem;
                r_den[k]  <= s_den;
            end
        end
    end

    assign o_quot   = r_quot[NS-1];
    assign o_rem_nz = |r_rem[NS-1];

endmodule

@@ hw/rtl/lrea_pick.sv @@
// edge pair choice, corner snap and clamp for one item
// depends on lrea_pkg
module lrea_pick (
    input  lrea_pkg::t_hits                  i_hits,
    input  logic [lrea_pkg::DIM_BITS-1:0]    i_w,
    input  logic [lrea_pkg::DIM_BITS-1:0]    i_h,
    input  logic [lrea_pkg::MARGIN_BITS-1:0] i_m,
    output lrea_pkg::t_result                o_res
);
    import lrea_pkg::*;

    localparam int KW = DELTA_BITS;

    logic signed [KW-1:0] xt, xb, yl, yr, w, h, m, y0, xs, kax, kay;
    logic                 first, ok;
    t_side                side;

    function automatic logic signed [KW-1:0] clamp_both(
        logic signed [KW-1:0] v, logic signed [KW-1:0] mm, logic signed [KW-1:0] len);
        if (v < mm) begin
            return mm;
        end
        if (v > len - mm) begin
            return len - mm;
        end
        return v;
    endfunction

    assign xt = KW'(i_hits.xt);
    assign xb = KW'(i_hits.xb);
    assign yl = KW'(i_hits.yl);
    assign yr = KW'(i_hits.yr);
    assign y0 = KW'(i_hits.y0);
    assign w  = $signed({{(KW-DIM_BITS){1'b0}}, i_w});
    assign h  = $signed({{(KW-DIM_BITS){1'b0}}, i_h});
    assign m  = $signed({{(KW-MARGIN_BITS){1'b0}}, i_m});

    // pair order decides, first pair that applies wins
    always_comb begin
        ok    = 1'b1;
        side  = SIDE_TOP_LEFT;
        kax   = '0;
        kay   = '0;
        first = 1'b0;
        xs    = '0;
        priority if (i_hits.vt && i_hits.vb) begin
            first = i_hits.dt < i_hits.db;
            xs    = first ? xt : xb;
            kay   = first ? '0 : h;
            if (xs < m) begin
                side = first ? SIDE_TOP_LEFT : SIDE_BOTTOM_LEFT;
                kax  = '0;
            end else if (w - xs < m) begin
                side = first ? SIDE_TOP_RIGHT : SIDE_BOTTOM_RIGHT;
                kax  = w;
            end else begin
                side = first ? SIDE_TOP : SIDE_BOTTOM;
                kax  = clamp_both(xs, m, w);
            end
        end else if (i_hits.vl && i_hits.vr) begin
            if (i_hits.dl < i_hits.dr) begin
                kax = '0;
                if (yl < m) begin
                    side = SIDE_TOP_LEFT;
                    kay  = '0;
                end else if (h - yl < m) begin
                    side = SIDE_BOTTOM_LEFT;
                    kay  = h;
                end else begin
                    side = SIDE_LEFT;
                    kay  = clamp_both(yl, m, h);
                end
            end else begin
                kax = w;
                if (yr < m && y0 < 0) begin
                    side = SIDE_TOP_RIGHT;
                    kay  = '0;
                end else if (h - yr < m && y0 > h) begin
                    side = SIDE_BOTTOM_RIGHT;
                    kay  = h;
                end else begin
                    side = SIDE_RIGHT;
                    kay  = clamp_both(yr, m, h);
                end
            end
        end else if (i_hits.vt && i_hits.vl) begin
            if (i_hits.dt <= i_hits.dl) begin
                kay = '0;
                if (w - xt < m) begin
                    side = SIDE_TOP_RIGHT;
                    kax  = w;
                end else begin
                    side = SIDE_TOP;
                    kax  = (xt < m) ? m : xt;
                end
            end else begin
                kax = '0;
                if (h - yl < m) begin
                    side = SIDE_BOTTOM_LEFT;
                    kay  = h;
                end else begin
                    side = SIDE_LEFT;
                    kay  = (yl < m) ? m : yl;
                end
            end
        end else if (i_hits.vt && i_hits.vr) begin
            if (i_hits.dt <= i_hits.dr) begin
                kay = '0;
                if (xt < m) begin
                    side = SIDE_TOP_LEFT;
                    kax  = '0;
                end else begin
                    side = SIDE_TOP;
                    kax  = (w - xt < m) ? w - m : xt;
                end
            end else begin
                kax = w;
                if (h - yr < m) begin
                    side = SIDE_BOTTOM_RIGHT;
                    kay  = h;
                end else begin
                    side = SIDE_RIGHT;
                    kay  = (yr < m) ? m : yr;
                end
            end
        end else if (i_hits.vb && i_hits.vr) begin
            if (i_hits.db <= i_hits.dr) begin
                kay = h;
                if (xb < m) begin
                    side = SIDE_BOTTOM_LEFT;
                    kax  = '0;
                end else begin
                    side = SIDE_BOTTOM;
                    kax  = (w - xb < m) ? w - m : xb;
                end
            end else begin
                kax = w;
                if (yr < m) begin
                    side = SIDE_TOP_RIGHT;
                    kay  = '0;
                end else begin
                    side = SIDE_RIGHT;
                    kay  = (h - yr < m) ? h - m : yr;
                end
            end
        end else if (i_hits.vb && i_hits.vl) begin
            if (i_hits.db <= i_hits.dl) begin
                kay = h;
                if (w - xb < m) begin
                    side = SIDE_BOTTOM_RIGHT;
                    kax  = w;
                end else begin
                    side = SIDE_BOTTOM;
                    kax  = (xb < m) ? m : xb;
                end
            end else begin
                kax = '0;
                if (yl < m) begin
                    side = SIDE_TOP_LEFT;
                    kay  = '0;
                end else begin
                    side = SIDE_LEFT;
                    kay  = (h - yl < m) ? h - m : yl;
                end
            end
        end else begin
            ok = 1'b0;
        end
    end

    // miss gives an all-zero result
    always_comb begin
        o_res.found = ok;
        o_res.side  = ok ? side : SIDE_TOP_LEFT;
        o_res.ax    = ok ? kax[COORD_BITS-1:0] : '0;
        o_res.ay    = ok ? kay[COORD_BITS-1:0] : '0;
    end

endmodule

@@ bench/tb.sv @@
// self-checking bench for line_rect_edge_anchor: random and directed point pairs
// depends on lrea_pkg and the line_rect_edge_anchor rtl
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lrea_pkg::*;

    typedef struct {
        logic       found;
        logic [2:0] side;
        logic [15:0] ax;
        logic [15:0] ay;
    } t_anchor;

    // scoreboard: predicts the anchor of each accepted point pair
    class t_anchor_board;
        longint wid, hgt, mrg;
        t_anchor pending[$];
        int mismatches;

        function new();
            wid = 100; hgt = 100; mrg = 1; mismatches = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, longint val);
            case (idx)
                CFG_RECT_WIDTH:  wid = val & 16'h7fff;
                CFG_RECT_HEIGHT: hgt = val & 16'h7fff;
                CFG_EDGE_MARGIN: mrg = val & 8'hff;
                default: ;
            endcase
        endfunction

        function longint absv(longint v);
            return v < 0 ? -v : v;
        endfunction

        // line coordinate at edge e, exact quotient truncated toward zero
        function longint cross_at(longint p0, longint q0, longint dp, longint dq, longint e);
            longint a, prod, uq, t, r, s;
            bit neg;
            a = e - q0;
            neg = ((a < 0) != (dp < 0)) != (dq < 0);
            prod = absv(a) * absv(dp);
            uq = absv(dq);
            t = prod / uq;
            r = prod % uq;
            if (t > (64'sd1 << 40)) t = 64'sd1 << 40;
            s = p0 + (neg ? -t : t);
            if (r != 0) begin
                if (s > 0 && neg) s = s - 1;
                else if (s < 0 && !neg) s = s + 1;
            end
            return s;
        endfunction

        function longint sq_dist(longint ax, longint ay, longint bx, longint by);
            return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
        endfunction

        function longint clamp2(longint v, longint m, longint len);
            if (v < m) return m;
            if (v > len - m) return len - m;
            return v;
        endfunction

        function void note_beat(logic signed [15:0] tx, logic signed [15:0] ty,
                                logic signed [15:0] lx, logic signed [15:0] ly);
            longint x0, y0, dx, dy, w, h, m, xt, xb, yl, yr, ax, ay, dt, db, dl, dr, xs;
            bit vt, vb, vl, vr, ok, tw;
            t_side sd;
            t_anchor res;
            x0 = tx; y0 = ty; dx = longint'(lx) - x0; dy = longint'(ly) - y0;
            w = wid; h = hgt; m = mrg;
            vt = 0; vb = 0; vl = 0; vr = 0; ok = 1; sd = SIDE_TOP_LEFT;
            ax = 0; ay = 0; dt = 0; db = 0; dl = 0; dr = 0;
            xt = 0; xb = 0; yl = 0; yr = 0;
            res = '{1'b0, 3'd0, 16'd0, 16'd0};
            if (dx == 0 && dy == 0) begin
                pending.push_back(res);
                return;
            end
            if (dy != 0 && w >= 1) begin
                xt = cross_at(x0, y0, dx, dy, 0);  vt = xt >= 0 && xt <= w;
                xb = cross_at(x0, y0, dx, dy, h);  vb = xb >= 0 && xb <= w;
            end
            if (dx != 0 && h >= 1) begin
                yl = cross_at(y0, x0, dy, dx, 0);  vl = yl >= 0 && yl <= h;
                yr = cross_at(y0, x0, dy, dx, w);  vr = yr >= 0 && yr <= h;
            end
            if (vt) dt = sq_dist(x0, y0, xt, 0);
            if (vb) db = sq_dist(x0, y0, xb, h);
            if (vl) dl = sq_dist(x0, y0, 0, yl);
            if (vr) dr = sq_dist(x0, y0, w, yr);
            if (vt && vb) begin
                tw = dt < db;
                xs = tw ? xt : xb;
                ay = tw ? 0 : h;
                if (xs < m) begin
                    sd = tw ? SIDE_TOP_LEFT : SIDE_BOTTOM_LEFT; ax = 0;
                end else if (w - xs < m) begin
                    sd = tw ? SIDE_TOP_RIGHT : SIDE_BOTTOM_RIGHT; ax = w;
                end else begin
                    sd = tw ? SIDE_TOP : SIDE_BOTTOM; ax = clamp2(xs, m, w);
                end
            end else if (vl && vr) begin
                if (dl < dr) begin
                    ax = 0;
                    if (yl < m) begin sd = SIDE_TOP_LEFT; ay = 0; end
                    else if (h - yl < m) begin sd = SIDE_BOTTOM_LEFT; ay = h; end
                    else begin sd = SIDE_LEFT; ay = clamp2(yl, m, h); end
                end else begin
                    ax = w;
                    if (yr < m && y0 < 0) begin sd = SIDE_TOP_RIGHT; ay = 0; end
                    else if (h - yr < m && y0 > h) begin sd = SIDE_BOTTOM_RIGHT; ay = h; end
                    else begin sd = SIDE_RIGHT; ay = clamp2(yr, m, h); end
                end
            end else if (vt && vl) begin
                if (dt <= dl) begin
                    ay = 0;
                    if (w - xt < m) begin sd = SIDE_TOP_RIGHT; ax = w; end
                    else begin sd = SIDE_TOP; ax = xt < m ? m : xt; end
                end else begin
                    ax = 0;
                    if (h - yl < m) begin sd = SIDE_BOTTOM_LEFT; ay = h; end
                    else begin sd = SIDE_LEFT; ay = yl < m ? m : yl; end
                end
            end else if (vt && vr) begin
                if (dt <= dr) begin
                    ay = 0;
                    if (xt < m) begin sd = SIDE_TOP_LEFT; ax = 0; end
                    else begin sd = SIDE_TOP; ax = (w - xt < m) ? w - m : xt; end
                end else begin
                    ax = w;
                    if (h - yr < m) begin sd = SIDE_BOTTOM_RIGHT; ay = h; end
                    else begin sd = SIDE_RIGHT; ay = yr < m ? m : yr; end
                end
            end else if (vb && vr) begin
                if (db <= dr) begin
                    ay = h;
                    if (xb < m) begin sd = SIDE_BOTTOM_LEFT; ax = 0; end
                    else begin sd = SIDE_BOTTOM; ax = (w - xb < m) ? w - m : xb; end
                end else begin
                    ax = w;
                    if (yr < m) begin sd = SIDE_TOP_RIGHT; ay = 0; end
                    else begin sd = SIDE_RIGHT; ay = (h - yr < m) ? h - m : yr; end
                end
            end else if (vb && vl) begin
                if (db <= dl) begin
                    ay = h;
                    if (w - xb < m) begin sd = SIDE_BOTTOM_RIGHT; ax = w; end
                    else begin sd = SIDE_BOTTOM; ax = xb < m ? m : xb; end
                end else begin
                    ax = 0;
                    if (yl < m) begin sd = SIDE_TOP_LEFT; ay = 0; end
                    else begin sd = SIDE_LEFT; ay = (h - yl < m) ? h - m : yl; end
                end
            end else begin
                ok = 0;
            end
            if (ok) res = '{1'b1, sd, ax[15:0], ay[15:0]};
            pending.push_back(res);
        endfunction

        function void check_beat(t_anchor got);
            t_anchor exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat");
                return;
            end
            exp = pending.pop_front();
            if (got.found !== exp.found || got.side !== exp.side ||
                got.ax !== exp.ax || got.ay !== exp.ay) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp f=%0d s=%0d x=%0d y=%0d got f=%0d s=%0d x=%0d y=%0d",
                             exp.found, exp.side, $signed(exp.ax), $signed(exp.ay),
                             got.found, got.side, $signed(got.ax), $signed(got.ay));
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] tip_x = '0, tip_y = '0, loc_x = '0, loc_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic found;
    logic [2:0] side;
    logic signed [15:0] anc_x, anc_y;
    logic hold_off = 1'b0;
    logic stall_free = 1'b0;

    t_anchor_board board = new();

    always #5 clk = ~clk;

    line_rect_edge_anchor dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_tip_x(tip_x), .i_tip_y(tip_y), .i_loc_x(loc_x), .i_loc_y(loc_y),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_found(found), .o_side(side), .o_anchor_x(anc_x), .o_anchor_y(anc_y)
    );

    // result monitor and checker
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_beat('{found, side, anc_x, anc_y});
    end

    // receiver stall pattern, with a long hold-off on request
    always @(negedge clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (hold_off) out_stall <= 1'b1;
        else if (stall_free) out_stall <= 1'b0;
        else if (r < 20) out_stall <= 1'b1;
        else if (r < 22) begin
            out_stall <= 1'b1;
            repeat ($urandom_range(20, 60)) @(negedge clk);
            out_stall <= 1'b0;
        end else out_stall <= 1'b0;
    end

    task automatic write_reg(t_cfg_idx idx, int val);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val[14:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, val);
    endtask

    // one input beat, with an optional random gap before it
    task automatic send_pair(logic signed [15:0] tx, logic signed [15:0] ty,
                             logic signed [15:0] lx, logic signed [15:0] ly, bit gaps);
        int r;
        r = $urandom_range(0, 99);
        if (gaps && r < 15) begin
            in_valid <= 1'b0;
            repeat (r < 2 ? $urandom_range(10, 40) : $urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        tip_x <= tx; tip_y <= ty; loc_x <= lx; loc_y <= ly;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_beat(tx, ty, lx, ly);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    function automatic logic signed [15:0] near_coord(int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        if (r == 1) return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
        return $signed(16'($urandom_range(0, span + 40))) - 16'sd20;
    endfunction

    task automatic random_pairs(int count, int span);
        logic signed [15:0] tx, ty, lx, ly;
        for (int k = 0; k < count; k++) begin
            tx = near_coord(span); ty = near_coord(span);
            lx = near_coord(span); ly = near_coord(span);
            if ($urandom_range(0, 19) == 0) begin lx = tx; ly = ty; end
            else if ($urandom_range(0, 9) == 0) ly = ty;
            else if ($urandom_range(0, 9) == 0) lx = tx;
            send_pair(tx, ty, lx, ly, 1'b1);
        end
    endtask

    initial begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: defaults, corners, edges, coincident, misses, extremes
        send_pair(-10, 50, 110, 50, 0);
        send_pair(50, -10, 50, 110, 0);
        send_pair(50, 110, 50, -10, 0);
        send_pair(110, 50, -10, 50, 0);
        send_pair(-5, -5, 105, 105, 0);
        send_pair(105, -5, -5, 105, 0);
        send_pair(0, 0, 0, 0, 0);
        send_pair(-50, -50, -40, -60, 0);
        send_pair(-32768, -32768, 32767, 32767, 0);
        send_pair(32767, -32768, -32768, 32767, 0);
        send_pair(-10, 99, 110, 101, 0);
        send_pair(110, -1, 120, 5, 0);
        send_pair(50, -20, 120, 50, 0);
        send_pair(-20, 50, 50, -20, 0);
        send_pair(50, 120, 120, 50, 0);
        send_pair(-20, 50, 50, 120, 0);
        send_pair(30, -20, 120, 60, 0);
        send_pair(-1, -32768, 1, 32767, 0);
        drain();

        // full width and margin extremes
        write_reg(CFG_RECT_WIDTH, 32767);
        write_reg(CFG_RECT_HEIGHT, 32767);
        write_reg(CFG_EDGE_MARGIN, 255);
        send_pair(-32768, 100, 32767, 200, 0);
        send_pair(200, -32768, 300, 32767, 0);
        random_pairs(200, 32767);
        drain();

        // tiny rectangle, margin larger than it
        write_reg(CFG_RECT_WIDTH, 1);
        write_reg(CFG_RECT_HEIGHT, 1);
        write_reg(CFG_EDGE_MARGIN, 200);
        random_pairs(200, 4);

        // long receiver hold-off while items keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (120) @(negedge clk);
                hold_off = 1'b0;
            end
            random_pairs(100, 4);
        join
        drain();

        // sizes from the middle and zero margin
        write_reg(CFG_RECT_WIDTH, 37);
        write_reg(CFG_RECT_HEIGHT, 300);
        write_reg(CFG_EDGE_MARGIN, 0);
        random_pairs(250, 300);
        drain();

        write_reg(CFG_RECT_WIDTH, 64);
        write_reg(CFG_RECT_HEIGHT, 48);
        write_reg(CFG_EDGE_MARGIN, 8);
        random_pairs(200, 64);
        stall_free = 1'b1;
        random_pairs(150, 64);
        stall_free = 1'b0;
        drain();

        write_reg(CFG_RECT_WIDTH, 100);
        write_reg(CFG_RECT_HEIGHT, 100);
        write_reg(CFG_EDGE_MARGIN, 1);
        random_pairs(400, 100);
        drain();

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

`default_nettype wire
